FILE: rtl/rprop_weight_update_defines.svh
// Assertion macros for the checker of the weight update block.
`ifndef RPROP_WEIGHT_UPDATE_DEFINES_SVH
`define RPROP_WEIGHT_UPDATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPWU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPWU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rpwu_pkg.sv
package rpwu_pkg;

   // Field and register widths.
   localparam int IDX_W     = 10;
   localparam int WORD_W    = 32;
   localparam int STEP_W    = 31;
   localparam int ETA_INC_W = 16;
   localparam int ETA_DEC_W = 15;
   localparam int SIGN_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 31;
   localparam int ETA_FRAC  = 14;
   localparam int PROD_W    = STEP_W + ETA_INC_W;
   localparam int SCALED_W  = PROD_W - ETA_FRAC;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ETA_INC   = 2'd0,
      CSR_ETA_DEC   = 2'd1,
      CSR_DELTA_MAX = 2'd2,
      CSR_DELTA_MIN = 2'd3
   } csr_addr_type;

   // Register reset values.
   localparam logic [ETA_INC_W-1:0] ETA_INC_RST   = 16'd19661;
   localparam logic [ETA_DEC_W-1:0] ETA_DEC_RST   = 15'd8192;
   localparam logic [STEP_W-1:0]    DELTA_MAX_RST = 31'd838860800;
   localparam logic [STEP_W-1:0]    DELTA_MIN_RST = 31'd17;

   // Stored gradient sign codes; the fourth code reads as no sign.
   localparam logic [SIGN_W-1:0] SIGN_NONE = 2'd0;
   localparam logic [SIGN_W-1:0] SIGN_POS  = 2'd1;
   localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'd2;

   // Item actions.
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_UPDATE = 1'b1;

   // Saturation bounds of a Q8.24 weight.
   localparam logic [WORD_W-1:0] WEIGHT_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] WEIGHT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic                     action;
      logic [IDX_W-1:0]         weight_index;
      logic signed [WORD_W-1:0] load_value;
      logic signed [WORD_W-1:0] gradient;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         result_index;
      logic signed [WORD_W-1:0] new_weight;
      logic [STEP_W-1:0]        new_step;
      logic                     saturated;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic mult;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

FILE: rtl/rpwu_ram.sv
module rpwu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/rpwu_ctrl.sv
module rpwu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rpwu_pkg::status_type status,
   output rpwu_pkg::cmd_type    cmd
);

   import rpwu_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_DONE
   } state_type;

   state_type state_ff;

   // Sequencer: accept, read the entry, scale the step, then write back and
   // hand over the beat once the output register is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: state_ff <= ST_MUL;
            ST_MUL:  state_ff <= ST_DONE;
            ST_DONE: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign cmd.take   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.mult   = (state_ff == ST_MUL);
   assign cmd.finish = (state_ff == ST_DONE) && status.out_free;

endmodule

FILE: rtl/rpwu_dpath.sv
module rpwu_dpath #(
   parameter int NUM_WEIGHTS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rpwu_pkg::req_type                  req_data,
   output rpwu_pkg::rsp_type                  rsp_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               csr_we,
   input  logic [rpwu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rpwu_pkg::CSR_W-1:0]         csr_wdata,
   input  rpwu_pkg::cmd_type                  cmd,
   output rpwu_pkg::status_type               status
);

   import rpwu_pkg::*;

   localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

   typedef enum logic [1:0] {
      MODE_KEEP,
      MODE_GROW,
      MODE_SHRINK
   } mode_type;

   logic [ETA_INC_W-1:0] eta_inc_ff;
   logic [ETA_DEC_W-1:0] eta_dec_ff;
   logic [STEP_W-1:0]    delta_max_ff;
   logic [STEP_W-1:0]    delta_min_ff;

   req_type              item_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [PROD_W-1:0]    prod_in;
   mode_type             mode_ff;
   mode_type             mode_in;
   logic [SIGN_W-1:0]    gsign_ff;
   logic [SIGN_W-1:0]    gsign_in;
   logic [STEP_W-1:0]    step_old_ff;
   logic [WORD_W-1:0]    weight_old_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 rsp_valid_ff;

   logic [IDX_W+AW-1:0]  idx_ext;
   logic [AW-1:0]        addr;
   logic                 in_range;
   logic [WORD_W-1:0]    weight_rd;
   logic [STEP_W-1:0]    step_rd;
   logic [SIGN_W-1:0]    sign_rd;
   logic [SIGN_W-1:0]    lsign;
   logic [ETA_INC_W-1:0] eta_sel;

   logic [SCALED_W-1:0]  scaled;
   logic [WORD_W-1:0]    prod32;
   logic [STEP_W-1:0]    step_new;
   logic [SIGN_W-1:0]    sign_new;
   logic [WORD_W:0]      wide_weight;
   logic [WORD_W:0]      wide_step;
   logic [WORD_W:0]      sum;
   logic [WORD_W-1:0]    weight_new;
   logic                 sat_new;
   logic                 mem_we;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         eta_inc_ff   <= ETA_INC_RST;
         eta_dec_ff   <= ETA_DEC_RST;
         delta_max_ff <= DELTA_MAX_RST;
         delta_min_ff <= DELTA_MIN_RST;
      end else if (csr_we) begin
         unique case (csr_addr_type'(csr_index))
            CSR_ETA_INC:   eta_inc_ff   <= csr_wdata[ETA_INC_W-1:0];
            CSR_ETA_DEC:   eta_dec_ff   <= csr_wdata[ETA_DEC_W-1:0];
            CSR_DELTA_MAX: delta_max_ff <= csr_wdata[STEP_W-1:0];
            CSR_DELTA_MIN: delta_min_ff <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Address of the entry and the range check.
   assign idx_ext  = {{AW{1'b0}}, item_ff.weight_index};
   assign addr     = idx_ext[AW-1:0];
   assign in_range = (32'(item_ff.weight_index) < 32'(NUM_WEIGHTS));

   // Per-entry stores.
   rpwu_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WEIGHTS)) u_weight_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (addr),
      .wdata (weight_new),
      .raddr (addr),
      .rdata (weight_rd)
   );

   rpwu_ram #(.WIDTH(STEP_W), .DEPTH(NUM_WEIGHTS)) u_step_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (addr),
      .wdata (step_new),
      .raddr (addr),
      .rdata (step_rd)
   );

   rpwu_ram #(.WIDTH(SIGN_W), .DEPTH(NUM_WEIGHTS)) u_sign_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (addr),
      .wdata (sign_new),
      .raddr (addr),
      .rdata (sign_rd)
   );

   // Sign classification and step scaling factor.
   always_comb begin
      if (item_ff.gradient == '0) begin
         gsign_in = SIGN_NONE;
      end else if (item_ff.gradient[WORD_W-1]) begin
         gsign_in = SIGN_NEG;
      end else begin
         gsign_in = SIGN_POS;
      end
      lsign = (sign_rd == SIGN_POS || sign_rd == SIGN_NEG) ? sign_rd : SIGN_NONE;
      if (gsign_in == SIGN_NONE || lsign == SIGN_NONE) begin
         mode_in = MODE_KEEP;
      end else if (gsign_in == lsign) begin
         mode_in = MODE_GROW;
      end else begin
         mode_in = MODE_SHRINK;
      end
      eta_sel = (mode_in == MODE_GROW) ? eta_inc_ff : {1'b0, eta_dec_ff};
      prod_in = PROD_W'(step_rd) * PROD_W'(eta_sel);
   end

   // Item capture and the multiply stage.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_ff <= req_data;
      end
      if (cmd.mult) begin
         prod_ff       <= prod_in;
         mode_ff       <= mode_in;
         gsign_ff      <= gsign_in;
         step_old_ff   <= step_rd;
         weight_old_ff <= weight_rd;
      end
   end

   // New step, new weight with saturation, and the result beat.
   always_comb begin
      scaled = prod_ff[PROD_W-1:ETA_FRAC];
      prod32 = scaled[SCALED_W-1] ? '1 : scaled[WORD_W-1:0];
      case (mode_ff)
         MODE_GROW: begin
            step_new = (prod32 > {1'b0, delta_max_ff}) ? delta_max_ff : prod32[STEP_W-1:0];
            sign_new = gsign_ff;
         end
         MODE_SHRINK: begin
            step_new = (prod32 < {1'b0, delta_min_ff}) ? delta_min_ff : prod32[STEP_W-1:0];
            sign_new = SIGN_NONE;
         end
         default: begin
            step_new = step_old_ff;
            sign_new = gsign_ff;
         end
      endcase

      wide_weight = {weight_old_ff[WORD_W-1], weight_old_ff};
      wide_step   = {2'b00, step_new};
      case (gsign_ff)
         SIGN_POS: sum = wide_weight - wide_step;
         SIGN_NEG: sum = wide_weight + wide_step;
         default:  sum = wide_weight;
      endcase
      sat_new = (sum[WORD_W] != sum[WORD_W-1]);
      if (sat_new) begin
         weight_new = sum[WORD_W] ? WEIGHT_MIN : WEIGHT_MAX;
      end else begin
         weight_new = sum[WORD_W-1:0];
      end

      // A load replaces everything the update computed.
      if (item_ff.action == ACT_LOAD) begin
         weight_new = item_ff.load_value;
         step_new   = delta_min_ff;
         sign_new   = SIGN_NONE;
         sat_new    = 1'b0;
      end

      rsp_in.result_index = item_ff.weight_index;
      if (in_range) begin
         rsp_in.new_weight = weight_new;
         rsp_in.new_step   = step_new;
         rsp_in.saturated  = sat_new;
      end else begin
         rsp_in.new_weight = '0;
         rsp_in.new_step   = '0;
         rsp_in.saturated  = 1'b0;
      end
   end

   assign mem_we = cmd.finish && in_range;

   // Output register; it holds its beat while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data        = rsp_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

FILE: rtl/rprop_weight_update.sv
// Channel | Direction | Handshake               | Beat
// req     | in        | req_valid / req_stall   | rpwu_pkg::req_type
// rsp     | out       | rsp_valid / rsp_stall   | rpwu_pkg::rsp_type
// csr     | in        | csr_we                  | csr_index, csr_wdata
//
// An item passes through capture, a registered read of the entry stores,
// the step multiply and write-back in that order; its result beat is registered
// at write-back, and the next item is not accepted until write-back completes.
// A stalled result holds the item in write-back until the output register frees.
// Reset is synchronous and clears the sequencer, the output valid and the
// configuration registers; the entry stores are valid only after a load.
module rprop_weight_update #(
   parameter int NUM_WEIGHTS = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rpwu_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rpwu_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [rpwu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rpwu_pkg::CSR_W-1:0]     csr_wdata
);

   import rpwu_pkg::*;

   cmd_type    cmd;
   status_type status;

   rpwu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rpwu_dpath #(.NUM_WEIGHTS(NUM_WEIGHTS)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

FILE: rtl/rpwu_checker.sv
`include "rprop_weight_update_defines.svh"

module rpwu_checker #(
   parameter int NUM_WEIGHTS = 1024
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input rpwu_pkg::rsp_type              rsp_data
);

   import rpwu_pkg::*;

   logic out_of_range;

   assign out_of_range = (32'(rsp_data.result_index) >= 32'(NUM_WEIGHTS));

   // A stalled result beat stays in place.
   `RPWU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result beat changed while stalled")

   // One item at a time: after an accepted beat the input stalls.
   `RPWU_ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall, "input accepted a second item before write-back")

   // An index beyond the table gives an empty result.
   `RPWU_ASSERT_SAME(a_oor_zero, clock, reset, rsp_valid && out_of_range, rsp_data.new_weight == '0 && rsp_data.new_step == '0 && !rsp_data.saturated, "out-of-range item gave a nonzero result")

   // A clipped weight sits exactly on a bound.
   `RPWU_ASSERT_SAME(a_sat_bound, clock, reset, rsp_valid && rsp_data.saturated, rsp_data.new_weight == WEIGHT_MAX || rsp_data.new_weight == WEIGHT_MIN, "saturated weight is not at a bound")

endmodule

bind rprop_weight_update rpwu_checker #(.NUM_WEIGHTS(NUM_WEIGHTS)) u_rpwu_checker (.*);
